### rtl/core/uri_authority_checker_macros.svh
// Assertion macros shared by the URI authority checker RTL.
// Every macro assumes a clock named aclk and an active-low reset named aresetn.
`ifndef URI_AUTHORITY_CHECKER_MACROS_SVH
`define URI_AUTHORITY_CHECKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UAC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/uac_pkg.sv
// Package for the URI authority checker: phase encoding, flag and result
// structures, character codes and register reset values. No dependencies.
`timescale 1ns / 1ps

package uac_pkg;

    localparam int MAP_W     = 32;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_PUNCT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_UPPER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_LOWER = 2'd2;

    localparam logic [MAP_W-1:0] MAP_PUNCT_RESET = 32'hAFFF_FFFA;
    localparam logic [MAP_W-1:0] MAP_UPPER_RESET = 32'hAFFF_FFFF;
    localparam logic [MAP_W-1:0] MAP_LOWER_RESET = 32'h47FF_FFFE;

    // Byte ranges covered by the three maps, selected by bits 6:5.
    localparam logic [1:0] RANGE_PUNCT = 2'b01;
    localparam logic [1:0] RANGE_UPPER = 2'b10;
    localparam logic [1:0] RANGE_LOWER = 2'b11;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_LBRKT = 8'h5B;
    localparam logic [7:0] CH_RBRKT = 8'h5D;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_SCHEME = 3'd1,
        PH_AUTH   = 3'd2,
        PH_SLASH  = 3'd3,
        PH_HOST   = 3'd4,
        PH_PORT   = 3'd5,
        PH_IPV6   = 3'd6,
        PH_DONE   = 3'd7
    } phase_t;

    typedef struct packed {
        logic port;
        logic host;
        logic user;
        logic scheme;
    } flags_t;

    typedef struct packed {
        logic allowed;
        logic slash;
        logic colon;
        logic at;
        logic lbrkt;
        logic rbrkt;
        logic end_delim;
    } char_class_t;

    typedef struct packed {
        flags_t flags;
        logic   status;
    } result_t;

endpackage

### rtl/core/uac_char_class.sv
// Character classifier: tests one byte against the allowed-character maps
// and decodes the delimiters the parser needs. Depends on uac_pkg.
`timescale 1ns / 1ps

module uac_char_class import uac_pkg::*; (
    input  logic [7:0]       char_byte,
    input  logic [MAP_W-1:0] map_punct,
    input  logic [MAP_W-1:0] map_upper,
    input  logic [MAP_W-1:0] map_lower,
    output char_class_t      cls
);

    logic [MAP_W-1:0] map_sel;

    always_comb begin
        unique case (char_byte[6:5])
            RANGE_PUNCT: map_sel = map_punct;
            RANGE_UPPER: map_sel = map_upper;
            RANGE_LOWER: map_sel = map_lower;
            default:     map_sel = '0;
        endcase
    end

    // Control bytes and anything from 0x80 up select no map bit.
    assign cls.allowed   = !char_byte[7] && (char_byte[6:5] != 2'b00)
                           && map_sel[char_byte[4:0]];
    assign cls.slash     = (char_byte == CH_SLASH);
    assign cls.colon     = (char_byte == CH_COLON);
    assign cls.at        = (char_byte == CH_AT);
    assign cls.lbrkt     = (char_byte == CH_LBRKT);
    assign cls.rbrkt     = (char_byte == CH_RBRKT);
    assign cls.end_delim = (char_byte == CH_SLASH) || (char_byte == CH_QUERY)
                           || (char_byte == CH_HASH);

endmodule

### rtl/core/uac_parser.sv
// Phase machine of the URI checker: holds the parse phase and presence flags
// and decides per byte whether a result is due. Depends on uac_pkg.
`timescale 1ns / 1ps

module uac_parser import uac_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        item_go,
    input  char_class_t cls,
    input  logic        is_last,
    output logic        emit,
    output result_t     result
);

    `include "uri_authority_checker_macros.svh"

    phase_t phase_reg, phase_next, phase_step;
    flags_t flags_reg, flags_next, flags_step;
    logic   bad;

    // Per-byte decision: stepped phase and flags, and whether a result falls.
    always_comb begin
        phase_step = phase_reg;
        flags_step = flags_reg;
        emit       = 1'b0;
        bad        = 1'b0;
        unique case (phase_reg)
            PH_DONE: begin
            end
            PH_SLASH: begin
                // The byte after "scheme:/" is not checked against the maps.
                if (cls.slash) begin
                    flags_step.scheme = 1'b1;
                    phase_step        = PH_HOST;
                end else begin
                    flags_step.port = 1'b1;
                    emit            = 1'b1;
                end
            end
            default: begin
                if (!cls.allowed) begin
                    emit = 1'b1;
                    bad  = 1'b1;
                end else begin
                    unique case (phase_reg)
                        PH_START: begin
                            if (cls.slash) begin
                                emit = 1'b1;
                            end else begin
                                flags_step.host = 1'b1;
                                priority if (cls.lbrkt) begin
                                    phase_step = PH_IPV6;
                                end else if (cls.colon) begin
                                    phase_step = PH_AUTH;
                                end else if (cls.at) begin
                                    flags_step.user = 1'b1;
                                    phase_step      = PH_HOST;
                                end else if (cls.end_delim) begin
                                    emit = 1'b1;
                                end else begin
                                    phase_step = PH_SCHEME;
                                end
                            end
                        end
                        PH_SCHEME: begin
                            priority if (cls.colon) begin
                                phase_step = PH_AUTH;
                            end else if (cls.at) begin
                                flags_step.user = 1'b1;
                                phase_step      = PH_HOST;
                            end else if (cls.end_delim) begin
                                emit = 1'b1;
                            end
                        end
                        PH_AUTH: begin
                            if (cls.slash) begin
                                if (is_last) begin
                                    flags_step.port = 1'b1;
                                end else begin
                                    phase_step = PH_SLASH;
                                end
                            end else begin
                                flags_step.port = 1'b1;
                                phase_step      = PH_PORT;
                            end
                        end
                        PH_HOST: begin
                            priority if (cls.at) begin
                                flags_step.user = 1'b1;
                            end else if (cls.lbrkt) begin
                                phase_step = PH_IPV6;
                            end else if (cls.colon) begin
                                flags_step.port = 1'b1;
                                phase_step      = PH_PORT;
                            end else if (cls.end_delim) begin
                                emit = 1'b1;
                            end
                        end
                        PH_PORT: begin
                            priority if (cls.at) begin
                                flags_step.port = 1'b0;
                                flags_step.user = 1'b1;
                                phase_step      = PH_HOST;
                            end else if (cls.lbrkt || cls.rbrkt || cls.colon) begin
                                emit = 1'b1;
                                bad  = 1'b1;
                            end else if (cls.end_delim) begin
                                flags_step.port = 1'b1;
                                emit            = 1'b1;
                            end
                        end
                        PH_IPV6: begin
                            priority if (cls.rbrkt) begin
                                phase_step = PH_HOST;
                            end else if (cls.at || cls.lbrkt || cls.end_delim) begin
                                emit = 1'b1;
                                bad  = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        endcase
        // A URI that is still open reports at its last byte.
        if ((phase_reg != PH_DONE) && is_last) begin
            emit = 1'b1;
        end
    end

    always_comb begin
        result.status = bad;
        result.flags  = bad ? flags_t'('0) : flags_step;
    end

    // Next phase: after a result the rest of the URI is dropped until its last byte.
    always_comb begin
        phase_next = phase_reg;
        flags_next = flags_reg;
        priority if (!item_go) begin
            phase_next = phase_reg;
        end else if (is_last) begin
            phase_next = PH_START;
            flags_next = '0;
        end else if (phase_reg == PH_DONE) begin
            phase_next = PH_DONE;
        end else if (emit) begin
            phase_next = PH_DONE;
            flags_next = flags_step;
        end else begin
            phase_next = phase_step;
            flags_next = flags_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            flags_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            flags_reg <= flags_next;
        end
    end

    `UAC_ASSERT_SAME(a_done_silent, item_go && (phase_reg == PH_DONE), !emit,
        "a dropped byte produced a result")
    `UAC_ASSERT_NEXT(a_last_restarts, item_go && is_last,
        (phase_reg == PH_START) && (flags_reg == '0),
        "the parser did not return to start after the last byte")
    `UAC_ASSERT_SAME(a_bad_clears_flags, emit && result.status, result.flags == '0,
        "an invalid result carries presence flags")

endmodule

### rtl/core/uri_authority_checker.sv
// Top level of the URI authority checker: input register, configuration
// registers, classifier, phase machine and result register. Depends on uac_pkg.
`timescale 1ns / 1ps

// The block takes a URI one byte per transfer on the s_ channel, with tlast on
// its final byte, and gives at most one result per URI on the m_ channel: as
// soon as a path delimiter, a misplaced delimiter or a bad byte decides the
// check, otherwise on the last byte; bytes after an early decision are
// dropped. It sustains one byte per clock while m_tready does not hold back a
// waiting result. A byte passes from the input register through the
// classifier and the phase machine into the result register, which drives
// m_tvalid. The three allowed-character maps are written through the cfg_
// port (index 0 covers 0x20 to 0x3F, 1 covers 0x40 to 0x5F, 2 covers 0x60 to
// 0x7F); the user must write them only while no URI is in flight, and the
// block itself does not enforce this.
module uri_authority_checker import uac_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input bytes.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] char_byte
    input  logic                 s_tlast,   // is_last
    // Results.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [0] status, [1] scheme_seen,
                                            // [2] userinfo_seen, [3] host_seen,
                                            // [4] port_seen, [7:5] zero
    // Configuration writes.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MAP_W-1:0]     cfg_data
);

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;
    logic             out_valid_reg, out_valid_next;
    result_t          out_data_reg;
    logic [MAP_W-1:0] map_punct_reg, map_upper_reg, map_lower_reg;

    char_class_t cls;
    logic        item_go;
    logic        emit;
    result_t     result;

    // A held byte is processed when the result register is free or draining.
    assign item_go  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || item_go;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (item_go) begin
            out_valid_next = emit;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (item_go && emit) begin
            out_data_reg <= result;
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_punct_reg <= MAP_PUNCT_RESET;
            map_upper_reg <= MAP_UPPER_RESET;
            map_lower_reg <= MAP_LOWER_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_MAP_PUNCT) begin
                map_punct_reg <= cfg_data;
            end
            if (cfg_index == CFG_MAP_UPPER) begin
                map_upper_reg <= cfg_data;
            end
            if (cfg_index == CFG_MAP_LOWER) begin
                map_lower_reg <= cfg_data;
            end
        end
    end

    uac_char_class u_char_class (
        .char_byte (in_byte_reg),
        .map_punct (map_punct_reg),
        .map_upper (map_upper_reg),
        .map_lower (map_lower_reg),
        .cls       (cls)
    );

    uac_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item_go (item_go),
        .cls     (cls),
        .is_last (in_last_reg),
        .emit    (emit),
        .result  (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_data_reg.flags.port, out_data_reg.flags.host,
                       out_data_reg.flags.user, out_data_reg.flags.scheme,
                       out_data_reg.status};

endmodule

### sim/tb.sv
// Self-checking testbench for uri_authority_checker: directed byte table, then random URIs
// under several map settings and handshake idling patterns. Depends on uac_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
    import uac_pkg::*;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = 8'h00;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_MAP_PUNCT;
    logic [MAP_W-1:0]     cfg_data  = '0;

    uri_authority_checker u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    typedef struct {
        logic [7:0] ch;
        logic       last;
        bit         typed;
        result_t    want;
    } byte_row_t;

    localparam result_t VERDICT_EMPTY = result_t'(5'b0_0000);
    localparam result_t VERDICT_BAD   = result_t'(5'b0_0001);

    // Shadow copy of the allowed maps and the parse state.
    logic [MAP_W-1:0] allow_punct = MAP_PUNCT_RESET;
    logic [MAP_W-1:0] allow_upper = MAP_UPPER_RESET;
    logic [MAP_W-1:0] allow_lower = MAP_LOWER_RESET;
    phase_t           uri_phase   = PH_START;
    flags_t           uri_flags   = '0;

    result_t    pending_verdicts[$];
    byte_row_t  directed_rows[$];
    logic [7:0] uri_bytes[$];
    int         mismatches   = 0;
    int         live_bytes   = 0;
    int         src_idle_pct = 0;
    int         sink_stall_pct = 0;
    string      word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-._~!$&*+,;=";
    string      hex_chars  = "0123456789abcdefABCDEF:";

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic byte_allowed(input logic [7:0] ch);
        logic [MAP_W-1:0] map;
        if (ch < 8'h20 || ch > 8'h7F)
            return 1'b0;
        case (ch[6:5])
            RANGE_PUNCT: map = allow_punct;
            RANGE_UPPER: map = allow_upper;
            default:     map = allow_lower;
        endcase
        return map[ch[4:0]];
    endfunction

    function automatic logic end_delim(input logic [7:0] ch);
        return ch == CH_SLASH || ch == CH_QUERY || ch == CH_HASH;
    endfunction

    // Forms the verdict for the current URI and moves the parser to done,
    // or back to start when this byte also ends the URI.
    function automatic result_t close_uri(input bit bad, input logic last);
        result_t r;
        r.status = bad;
        r.flags  = bad ? flags_t'('0) : uri_flags;
        if (last) begin
            uri_phase = PH_START;
            uri_flags = '0;
        end else begin
            uri_phase = PH_DONE;
        end
        return r;
    endfunction

    // Advances the parser by one byte; returns 1 when that byte yields a verdict.
    function automatic bit parse_byte(input logic [7:0] ch, input logic last,
                                      output result_t verdict);
        verdict = VERDICT_EMPTY;
        if (uri_phase == PH_DONE) begin
            if (last) begin
                uri_phase = PH_START;
                uri_flags = '0;
            end
            return 1'b0;
        end
        // The byte after "scheme:/" is never tested against the maps.
        if (uri_phase == PH_SLASH) begin
            if (ch == CH_SLASH) begin
                uri_flags.scheme = 1'b1;
                uri_phase = PH_HOST;
                if (last) begin
                    verdict = close_uri(1'b0, 1'b1);
                    return 1'b1;
                end
                return 1'b0;
            end
            uri_flags.port = 1'b1;
            verdict = close_uri(1'b0, last);
            return 1'b1;
        end
        if (!byte_allowed(ch)) begin
            verdict = close_uri(1'b1, last);
            return 1'b1;
        end
        case (uri_phase)
            PH_START, PH_SCHEME: begin
                if (uri_phase == PH_START && ch == CH_SLASH) begin
                    verdict = close_uri(1'b0, last);
                    return 1'b1;
                end
                if (uri_phase == PH_START) begin
                    uri_flags.host = 1'b1;
                    uri_phase = (ch == CH_LBRKT) ? PH_IPV6 : PH_SCHEME;
                end
                if (uri_phase == PH_SCHEME) begin
                    if (ch == CH_COLON) begin
                        uri_phase = PH_AUTH;
                    end else if (ch == CH_AT) begin
                        uri_flags.user = 1'b1;
                        uri_phase = PH_HOST;
                    end else if (end_delim(ch)) begin
                        verdict = close_uri(1'b0, last);
                        return 1'b1;
                    end
                end
            end
            PH_AUTH: begin
                if (ch == CH_SLASH) begin
                    if (last) begin
                        uri_flags.port = 1'b1;
                        verdict = close_uri(1'b0, 1'b1);
                        return 1'b1;
                    end
                    uri_phase = PH_SLASH;
                end else begin
                    uri_flags.port = 1'b1;
                    uri_phase = PH_PORT;
                end
            end
            PH_HOST: begin
                if (ch == CH_AT) begin
                    uri_flags.user = 1'b1;
                end else if (ch == CH_LBRKT) begin
                    uri_phase = PH_IPV6;
                end else if (ch == CH_COLON) begin
                    uri_flags.port = 1'b1;
                    uri_phase = PH_PORT;
                end else if (end_delim(ch)) begin
                    verdict = close_uri(1'b0, last);
                    return 1'b1;
                end
            end
            PH_PORT: begin
                if (ch == CH_AT) begin
                    uri_flags.port = 1'b0;
                    uri_flags.user = 1'b1;
                    uri_phase = PH_HOST;
                end else if (ch == CH_LBRKT || ch == CH_RBRKT || ch == CH_COLON) begin
                    verdict = close_uri(1'b1, last);
                    return 1'b1;
                end else if (end_delim(ch)) begin
                    uri_flags.port = 1'b1;
                    verdict = close_uri(1'b0, last);
                    return 1'b1;
                end
            end
            default: begin
                if (ch == CH_RBRKT) begin
                    uri_phase = PH_HOST;
                end else if (ch == CH_AT || ch == CH_LBRKT || end_delim(ch)) begin
                    verdict = close_uri(1'b1, last);
                    return 1'b1;
                end
            end
        endcase
        if (last) begin
            verdict = close_uri(1'b0, 1'b1);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void add_row(input logic [7:0] ch, input logic last,
                                    input bit typed, input result_t want);
        byte_row_t row;
        row.ch    = ch;
        row.last  = last;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    task automatic add_word(input int lo, input int hi);
        int n;
        n = $urandom_range(lo, hi);
        repeat (n) uri_bytes.push_back(word_chars[$urandom_range(0, word_chars.len() - 1)]);
    endtask

    // Builds one URI: mostly well-formed with random content, some corrupted,
    // a few pure noise.
    task automatic build_uri();
        int n;
        int k;
        uri_bytes.delete();
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 8);
            repeat (n) uri_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 1) == 1) begin
            add_word(1, 5);
            uri_bytes.push_back(CH_COLON);
            k = $urandom_range(0, 9);
            if (k < 8) begin
                uri_bytes.push_back(CH_SLASH);
                uri_bytes.push_back(CH_SLASH);
            end else if (k == 8) begin
                uri_bytes.push_back(CH_SLASH);
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            add_word(1, 4);
            uri_bytes.push_back(CH_AT);
        end
        if ($urandom_range(0, 4) == 0) begin
            uri_bytes.push_back(CH_LBRKT);
            n = $urandom_range(1, 6);
            repeat (n) uri_bytes.push_back(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
            if ($urandom_range(0, 5) != 0)
                uri_bytes.push_back(CH_RBRKT);
        end else begin
            add_word(1, 6);
        end
        if ($urandom_range(0, 2) == 0) begin
            uri_bytes.push_back(CH_COLON);
            n = $urandom_range(0, 4);
            repeat (n) uri_bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
        end
        k = $urandom_range(0, 5);
        if (k < 3) begin
            uri_bytes.push_back(k == 0 ? CH_SLASH : (k == 1 ? CH_QUERY : CH_HASH));
            add_word(0, 4);
        end
        if ($urandom_range(0, 4) == 0)
            uri_bytes[$urandom_range(0, uri_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 6))
                0:       k = CH_SLASH;
                1:       k = CH_QUERY;
                2:       k = CH_HASH;
                3:       k = CH_COLON;
                4:       k = CH_AT;
                5:       k = CH_LBRKT;
                default: k = CH_RBRKT;
            endcase
            uri_bytes[$urandom_range(0, uri_bytes.size() - 1)] = 8'(k);
        end
    endtask

    // Presents one byte and returns once its transfer has taken place; tvalid
    // is left high so that the next byte can follow without a gap.
    task automatic send_byte(input logic [7:0] ch, input logic last,
                             input bit typed, input result_t want);
        result_t predicted;
        bit      fires;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        if (uri_phase != PH_DONE)
            live_bytes++;
        fires = parse_byte(ch, last, predicted);
        if (typed)
            pending_verdicts.push_back(want);
        else if (fires)
            pending_verdicts.push_back(predicted);
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge aclk);
        // A dropped byte may still sit in the pipeline.
        repeat (6) @(posedge aclk);
    endtask

    // Leaves cfg_valid high so that writes can follow back to back.
    task automatic write_map(input logic [CFG_IDX_W-1:0] idx, input logic [MAP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        case (idx)
            CFG_MAP_PUNCT: allow_punct = value;
            CFG_MAP_UPPER: allow_upper = value;
            default:       allow_lower = value;
        endcase
    endtask

    task automatic load_maps(input logic [MAP_W-1:0] punct, input logic [MAP_W-1:0] upper,
                             input logic [MAP_W-1:0] lower);
        write_map(CFG_MAP_PUNCT, punct);
        write_map(CFG_MAP_UPPER, upper);
        write_map(CFG_MAP_LOWER, lower);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [2:0] want, input logic [2:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                $error("unexpected result transfer, tdata %0h", m_tdata);
                mismatches++;
            end else begin
                want = pending_verdicts.pop_front();
                check_field("status", 3'(want.status), 3'(m_tdata[0]));
                check_field("scheme_seen", 3'(want.flags.scheme), 3'(m_tdata[1]));
                check_field("userinfo_seen", 3'(want.flags.user), 3'(m_tdata[2]));
                check_field("host_seen", 3'(want.flags.host), 3'(m_tdata[3]));
                check_field("port_seen", 3'(want.flags.port), 3'(m_tdata[4]));
                check_field("tdata padding", 3'b000, m_tdata[7:5]);
            end
        end
    end

    initial begin
        logic [MAP_W-1:0] one_bit;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table under the reset maps.
        add_row(CH_SLASH, 1'b1, 1'b1, VERDICT_EMPTY);
        add_row(8'h00,    1'b1, 1'b1, VERDICT_BAD);
        add_row(8'hFF,    1'b1, 1'b1, VERDICT_BAD);
        add_row("a",      1'b0, 1'b0, VERDICT_EMPTY);
        add_row(CH_COLON, 1'b0, 1'b0, VERDICT_EMPTY);
        add_row(CH_SLASH, 1'b0, 1'b0, VERDICT_EMPTY);
        add_row(CH_SLASH, 1'b0, 1'b0, VERDICT_EMPTY);
        add_row("h",      1'b0, 1'b0, VERDICT_EMPTY);
        add_row(CH_COLON, 1'b0, 1'b0, VERDICT_EMPTY);
        add_row("9",      1'b0, 1'b0, VERDICT_EMPTY);
        add_row(CH_QUERY, 1'b0, 1'b0, VERDICT_EMPTY);
        add_row("x",      1'b1, 1'b0, VERDICT_EMPTY);   // dropped after the decision
        add_row("a",      1'b0, 1'b0, VERDICT_EMPTY);
        add_row(CH_COLON, 1'b0, 1'b0, VERDICT_EMPTY);
        add_row(CH_SLASH, 1'b1, 1'b0, VERDICT_EMPTY);   // single slash ends the URI
        add_row(CH_LBRKT, 1'b0, 1'b0, VERDICT_EMPTY);
        add_row(CH_COLON, 1'b0, 1'b0, VERDICT_EMPTY);
        add_row(CH_RBRKT, 1'b0, 1'b0, VERDICT_EMPTY);
        add_row(CH_RBRKT, 1'b0, 1'b0, VERDICT_EMPTY);   // ordinary byte in the host
        add_row(CH_HASH,  1'b0, 1'b0, VERDICT_EMPTY);
        add_row(8'h80,    1'b1, 1'b0, VERDICT_EMPTY);
        add_row("h",      1'b0, 1'b0, VERDICT_EMPTY);
        add_row(CH_COLON, 1'b0, 1'b0, VERDICT_EMPTY);
        add_row("9",      1'b0, 1'b0, VERDICT_EMPTY);
        add_row(CH_AT,    1'b0, 1'b0, VERDICT_EMPTY);   // port turns out to be userinfo
        add_row(8'h7F,    1'b1, 1'b0, VERDICT_EMPTY);
        foreach (directed_rows[i])
            send_byte(directed_rows[i].ch, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].want);
        wait_drained();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 47; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 47; end
                default: begin src_idle_pct = 30; sink_stall_pct = 30; end
            endcase
            one_bit = 32'd1 << $urandom_range(0, 31);
            case (phase)
                1: load_maps('1, '1, '1);
                2: load_maps($urandom, $urandom, $urandom);
                3: load_maps('0, '0, '0);
                4, 6: load_maps(MAP_PUNCT_RESET ^ one_bit, MAP_UPPER_RESET ^ (one_bit >> 1),
                                MAP_LOWER_RESET ^ (32'd1 << $urandom_range(0, 31)));
                5: load_maps($urandom, $urandom, $urandom);
                7: load_maps(MAP_PUNCT_RESET, MAP_UPPER_RESET, MAP_LOWER_RESET);
                default: ;
            endcase
            live_bytes = 0;
            while (live_bytes < 50) begin
                build_uri();
                foreach (uri_bytes[i])
                    send_byte(uri_bytes[i], i == uri_bytes.size() - 1, 1'b0, VERDICT_EMPTY);
            end
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/uac_pkg.sv
rtl/core/uac_char_class.sv
rtl/core/uac_parser.sv
rtl/core/uri_authority_checker.sv
sim/tb.sv
